>>> hw/rtl/point_segment_distance_defines.svh
// ----------------------------------------------------------------------------
// point_segment_distance_defines
// assertion macros used by the psd_cell bit cells of the distance pipeline
// ----------------------------------------------------------------------------
`ifndef POINT_SEGMENT_DISTANCE_DEFINES_SVH
`define POINT_SEGMENT_DISTANCE_DEFINES_SVH

// condition that holds at every edge outside reset
`define PSD_ASSERT_NOW(name, cond) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("psd: check failed");

// implication into the next cycle, also checked across reset
`define PSD_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge i_clk) (pre) |=> (post)) \
        else $error("psd: check failed");

`endif

>>> hw/rtl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// shared constants and register indexes of the point to segment distance block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psd_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 8;

    typedef enum logic [1:0] {
        CFG_START_X = 2'd0,
        CFG_START_Y = 2'd1,
        CFG_END_X   = 2'd2,
        CFG_END_Y   = 2'd3
    } t_cfg_idx;

endpackage

>>> hw/rtl/point_segment_distance.sv
// ----------------------------------------------------------------------------
// point_segment_distance
// euclidean distance from a query point to a fixed 2d segment, unsigned q.8
// ----------------------------------------------------------------------------
// Takes one request per clock unless o_stall is high, and returns one distance
// per request, in order. Five front stages form the differences, dot and cross
// products and pick the case; the rest is a chain of COORD_WIDTH + FRAC_BITS + 1
// cells, one per result bit, each resolving one bit of either a square root or
// the quotient |cross| / |B-A|. The whole pipeline holds while a finished result
// is stalled.
`timescale 1ns / 1ps

module point_segment_distance #(
    parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = psd_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  psd_pkg::t_cfg_idx                  i_cfg_addr,
    input  logic [COORD_WIDTH-1:0]             i_cfg_wdata,
    // request channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [COORD_WIDTH-1:0]      i_point_x,
    input  logic signed [COORD_WIDTH-1:0]      i_point_y,
    // result channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [COORD_WIDTH+FRAC_BITS:0]     o_distance_q8
);

    import psd_pkg::*;

    localparam int MW  = 2 * COORD_WIDTH + 1;
    localparam int NW  = 2 * MW + 2 * FRAC_BITS;
    localparam int QW  = COORD_WIDTH + FRAC_BITS + 1;
    // widest intermediate of the bit search: 2^(2qw+mw) bound plus headroom
    localparam int W   = 2 * QW + MW + 1;

    // segment end points
    logic signed [COORD_WIDTH-1:0] r_ax, r_ay, r_bx, r_by;

    // one enable for every stage: hold all while a result waits
    logic w_en;

    logic          f_valid;
    logic [NW-1:0] f_n;
    logic [MW-1:0] f_m;

    // links between cells, index 0 is the chain input
    logic          c_valid [0:QW];
    logic [W-1:0]  c_d     [0:QW];
    logic [W-1:0]  c_r     [0:QW];
    logic [MW-1:0] c_m     [0:QW];
    logic [QW-1:0] c_q     [0:QW];

    assign o_stall = o_valid & i_stall;
    assign w_en    = ~o_stall;

    // register writes: the user must write only while idle; the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax <= '0;
            r_ay <= '0;
            r_bx <= '0;
            r_by <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_START_X: r_ax <= i_cfg_wdata;
                CFG_START_Y: r_ay <= i_cfg_wdata;
                CFG_END_X:   r_bx <= i_cfg_wdata;
                CFG_END_Y:   r_by <= i_cfg_wdata;
                default:     ;
            endcase
        end
    end

    // front end reduces every case to n and m: length cases have m = 1
    psd_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (i_valid),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_ax      (r_ax),
        .i_ay      (r_ay),
        .i_bx      (r_bx),
        .i_by      (r_by),
        .o_valid   (f_valid),
        .o_n       (f_n),
        .o_m       (f_m)
    );

    // chain starts with the full remainder and q = 0
    assign c_valid[0] = f_valid;
    assign c_d[0]     = W'(f_n);
    assign c_r[0]     = '0;
    assign c_m[0]     = f_m;
    assign c_q[0]     = '0;

    // most significant bit first
    for (genvar k = 0; k < QW; k++) begin : g_cell
        psd_cell #(
            .W   (W),
            .MW  (MW),
            .QW  (QW),
            .BIT (QW - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (c_valid[k]),
            .i_d     (c_d[k]),
            .i_r     (c_r[k]),
            .i_m     (c_m[k]),
            .i_q     (c_q[k]),
            .o_valid (c_valid[k+1]),
            .o_d     (c_d[k+1]),
            .o_r     (c_r[k+1]),
            .o_m     (c_m[k+1]),
            .o_q     (c_q[k+1])
        );
    end

    // last cell is the output register
    assign o_valid       = c_valid[QW];
    assign o_distance_q8 = c_q[QW];

endmodule

>>> hw/rtl/psd_front.sv
// ----------------------------------------------------------------------------
// psd_front
// differences, products and case selection ahead of the root/divide chain
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psd_front #(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic signed [COORD_WIDTH-1:0] i_ax,
    input  logic signed [COORD_WIDTH-1:0] i_ay,
    input  logic signed [COORD_WIDTH-1:0] i_bx,
    input  logic signed [COORD_WIDTH-1:0] i_by,
    output logic                          o_valid,
    output logic [2*(2*COORD_WIDTH+1)+2*FRAC_BITS-1:0] o_n,
    output logic [2*COORD_WIDTH:0]        o_m
);

    localparam int DW  = COORD_WIDTH + 1;
    localparam int PW  = 2 * DW;
    localparam int SW  = PW + 1;
    localparam int CRW = 2 * COORD_WIDTH + 1;
    localparam int MW  = CRW;
    localparam int NW  = 2 * CRW + 2 * FRAC_BITS;

    // stage 0: differences
    logic                 r0_valid;
    logic signed [DW-1:0] r0_sx, r0_sy, r0_ex, r0_ey, r0_gx, r0_gy;
    // stage 1: products
    logic                 r1_valid;
    logic signed [PW-1:0] r1_sxgx, r1_sygy, r1_exgx, r1_eygy, r1_sxey, r1_syex;
    logic signed [PW-1:0] r1_sxsx, r1_sysy, r1_exex, r1_eyey, r1_gxgx, r1_gygy;
    // stage 2: sums
    logic                 r2_valid;
    logic signed [SW-1:0] r2_dot_s, r2_dot_e, r2_cross;
    logic [MW-1:0]        r2_d2s, r2_d2e, r2_l2;
    // stage 3: case selection
    logic                 r3_valid;
    logic                 r3_int;
    logic [CRW-1:0]       r3_x;
    logic [MW-1:0]        r3_l2;
    // stage 4
    logic                 r4_valid;
    logic [NW-1:0]        r4_n;
    logic [MW-1:0]        r4_m;

    logic signed [DW-1:0] w_px, w_py, w_ax, w_ay, w_bx, w_by;
    logic signed [SW-1:0] w_abs_cross;
    logic                 w_int;
    logic [2*CRW-1:0]     w_sq;
    logic [2*CRW-1:0]     w_base;

    assign w_px = $signed({i_point_x[COORD_WIDTH-1], i_point_x});
    assign w_py = $signed({i_point_y[COORD_WIDTH-1], i_point_y});
    assign w_ax = $signed({i_ax[COORD_WIDTH-1], i_ax});
    assign w_ay = $signed({i_ay[COORD_WIDTH-1], i_ay});
    assign w_bx = $signed({i_bx[COORD_WIDTH-1], i_bx});
    assign w_by = $signed({i_by[COORD_WIDTH-1], i_by});

    // interior only when p lies strictly between the two end normals
    assign w_int       = (r2_dot_s > 0) && (r2_dot_e < 0);
    assign w_abs_cross = r2_cross[SW-1] ? -r2_cross : r2_cross;
    assign w_sq        = r3_x * r3_x;
    assign w_base      = r3_int ? w_sq : {{CRW{1'b0}}, r3_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r0_valid <= i_valid;
            r1_valid <= r0_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_sx <= w_px - w_ax;
            r0_sy <= w_py - w_ay;
            r0_ex <= w_px - w_bx;
            r0_ey <= w_py - w_by;
            r0_gx <= w_bx - w_ax;
            r0_gy <= w_by - w_ay;

            r1_sxgx <= r0_sx * r0_gx;
            r1_sygy <= r0_sy * r0_gy;
            r1_exgx <= r0_ex * r0_gx;
            r1_eygy <= r0_ey * r0_gy;
            r1_sxey <= r0_sx * r0_ey;
            r1_syex <= r0_sy * r0_ex;
            r1_sxsx <= r0_sx * r0_sx;
            r1_sysy <= r0_sy * r0_sy;
            r1_exex <= r0_ex * r0_ex;
            r1_eyey <= r0_ey * r0_ey;
            r1_gxgx <= r0_gx * r0_gx;
            r1_gygy <= r0_gy * r0_gy;

            r2_dot_s <= $signed({r1_sxgx[PW-1], r1_sxgx}) + $signed({r1_sygy[PW-1], r1_sygy});
            r2_dot_e <= $signed({r1_exgx[PW-1], r1_exgx}) + $signed({r1_eygy[PW-1], r1_eygy});
            r2_cross <= $signed({r1_sxey[PW-1], r1_sxey}) - $signed({r1_syex[PW-1], r1_syex});
            r2_d2s   <= {1'b0, r1_sxsx[2*COORD_WIDTH-1:0]} + {1'b0, r1_sysy[2*COORD_WIDTH-1:0]};
            r2_d2e   <= {1'b0, r1_exex[2*COORD_WIDTH-1:0]} + {1'b0, r1_eyey[2*COORD_WIDTH-1:0]};
            r2_l2    <= {1'b0, r1_gxgx[2*COORD_WIDTH-1:0]} + {1'b0, r1_gygy[2*COORD_WIDTH-1:0]};

            r3_int <= w_int;
            r3_l2  <= r2_l2;
            if (w_int) begin
                r3_x <= w_abs_cross[CRW-1:0];
            end else if (r2_dot_s <= 0) begin
                r3_x <= r2_d2s;
            end else begin
                r3_x <= r2_d2e;
            end

            r4_n <= NW'(w_base) << (2 * FRAC_BITS);
            r4_m <= r3_int ? r3_l2 : MW'(1);
        end
    end

    assign o_valid = r4_valid;
    assign o_n     = r4_n;
    assign o_m     = r4_m;

endmodule

>>> hw/rtl/psd_cell.sv
// ----------------------------------------------------------------------------
// psd_cell
// one result bit of the search for the largest q with q*q*m <= n
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psd_cell #(
    parameter int W   = 84,
    parameter int MW  = 33,
    parameter int QW  = 25,
    parameter int BIT = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [W-1:0]  i_d,
    input  logic [W-1:0]  i_r,
    input  logic [MW-1:0] i_m,
    input  logic [QW-1:0] i_q,
    output logic          o_valid,
    output logic [W-1:0]  o_d,
    output logic [W-1:0]  o_r,
    output logic [MW-1:0] o_m,
    output logic [QW-1:0] o_q
);

    `include "point_segment_distance_defines.svh"

    localparam logic [QW-1:0] LOW_MASK = (QW'(1) << BIT) - QW'(1);

    logic          r_valid;
    logic [W-1:0]  r_d, r_r;
    logic [MW-1:0] r_m;
    logic [QW-1:0] r_q;

    logic [W-1:0]  w_t;
    logic          w_take;

    // (q + 2^b)^2 m - q^2 m = q m 2^(b+1) + m 2^(2b)
    assign w_t    = (i_r << (BIT + 1)) + (W'(i_m) << (2 * BIT));
    assign w_take = (i_d >= w_t);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m <= i_m;
            r_d <= w_take ? (i_d - w_t) : i_d;
            r_r <= w_take ? (i_r + (W'(i_m) << BIT)) : i_r;
            r_q <= i_q | (QW'(w_take) << BIT);
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;
    assign o_r     = r_r;
    assign o_m     = r_m;
    assign o_q     = r_q;

    `PSD_ASSERT_NEXT(a_rst_clears, !i_rst_n, !r_valid)
    `PSD_ASSERT_NEXT(a_valid_moves, i_rst_n && i_en, r_valid == $past(i_valid))
    `PSD_ASSERT_NOW(a_low_bits_clear, r_valid |-> ((r_q & LOW_MASK) == '0))

endmodule
